@@ design/ffba_pkg.sv @@
// Package for the first-fit bin allocator: default parameters, field widths,
// the status code enum, the controller state enum and the result struct.
// No dependencies.
package ffba_pkg;

	localparam int MAX_BINS_DEF  = 64;
	localparam int SIZE_BITS_DEF = 16;
	localparam int CAP_RESET     = 65535;

	localparam int ITEM_W  = 16;
	localparam int INDEX_W = 6;
	localparam int USED_W  = 7;

	typedef enum logic [1:0] {
		ST_EXISTING  = 2'd0,
		ST_NEW       = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_BIN    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [INDEX_W-1:0] bin_index;
		status_t            status;
		logic [USED_W-1:0]  bins_used;
	} res_t;

endpackage

@@ design/ffba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/ffba_ctrl.sv @@
// Allocation sequencer: scans the capacity RAM for the first fitting bin,
// writes back the reduced capacity or opens a new bin, and builds the result.
// Depends on ffba_pkg.
module ffba_ctrl import ffba_pkg::*; #(
	parameter int MAX_BINS  = MAX_BINS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [SIZE_BITS-1:0]        cap,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [SIZE_BITS-1:0]        in_size,
	input  logic                        in_last,
	output logic                        res_valid,
	input  logic                        res_take,
	output res_t                        res,
	output logic                        ram_we,
	output logic [$clog2(MAX_BINS)-1:0] ram_waddr,
	output logic [SIZE_BITS-1:0]        ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(MAX_BINS)-1:0] ram_raddr,
	input  logic [SIZE_BITS-1:0]        ram_rdata
);

	localparam int IdxW = $clog2(MAX_BINS);
	localparam int CntW = $clog2(MAX_BINS + 1);

	state_t              state_q, state_d;
	logic [SIZE_BITS-1:0] size_q;
	logic                last_q;
	logic [CntW-1:0]     cnt_q, cnt_d;
	logic [CntW-1:0]     rd_ptr_q;
	logic                rd_vld_s1;
	logic [IdxW-1:0]     rd_addr_s1;
	res_t                res_q, res_d;

	logic            issue, too_large, check_new, fit_hit, scan_end;
	logic            has_room, open_new, decide;
	logic [IdxW-1:0] chosen;
	logic [31:0]     chosen_ext, cnt_ext;

	always_comb begin
		issue     = (state_q == S_SCAN) && (rd_ptr_q < cnt_q);
		too_large = (state_q == S_CHECK) && (size_q > cap);
		check_new = (state_q == S_CHECK) && !(size_q > cap) && (cnt_q == '0);
		fit_hit   = (state_q == S_SCAN) && rd_vld_s1 && (ram_rdata >= size_q);
		scan_end  = (state_q == S_SCAN) && rd_vld_s1 && !(ram_rdata >= size_q)
			&& ((CntW'(rd_addr_s1) + CntW'(1)) == cnt_q);
		has_room  = cnt_q < CntW'(MAX_BINS);
		open_new  = (check_new || scan_end) && has_room;
		decide    = too_large || check_new || fit_hit || scan_end;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = decide ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				if (decide) state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: RAM access and result
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_DONE);
		res       = res_q;

		ram_re    = issue;
		ram_raddr = rd_ptr_q[IdxW-1:0];

		chosen    = fit_hit ? rd_addr_s1 : (open_new ? cnt_q[IdxW-1:0] : '0);
		ram_we    = fit_hit || open_new;
		ram_waddr = chosen;
		ram_wdata = fit_hit ? (ram_rdata - size_q) : (cap - size_q);

		cnt_d      = open_new ? (cnt_q + CntW'(1)) : cnt_q;
		chosen_ext = 32'(chosen);
		cnt_ext    = 32'(cnt_d);

		res_d.bin_index = chosen_ext[INDEX_W-1:0];
		res_d.bins_used = cnt_ext[USED_W-1:0];
		if (too_large) begin
			res_d.status = ST_TOO_LARGE;
		end else if (fit_hit) begin
			res_d.status = ST_EXISTING;
		end else if (open_new) begin
			res_d.status = ST_NEW;
		end else begin
			res_d.status = ST_NO_BIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK) begin
				rd_ptr_q  <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN) begin
				rd_vld_s1 <= issue;
				if (issue) rd_ptr_q <= rd_ptr_q + CntW'(1);
			end
			// last item of a set: result keeps the count, the set starts empty
			if (decide) cnt_q <= last_q ? '0 : cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			size_q <= in_size;
			last_q <= in_last;
		end
		if (state_q == S_SCAN) rd_addr_s1 <= rd_ptr_q[IdxW-1:0];
		if (decide) res_q <= res_d;
	end

endmodule

@@ design/first_fit_bin_allocator.sv @@
// First-fit bin allocator, top level: capacity register, output register,
// allocation sequencer and capacity RAM. Depends on ffba_pkg, ffba_ctrl, ffba_ram.
//
// Usage: an item (item_size, last_item) is taken when in_valid is high and
// in_stall low. It is placed in the lowest open bin with enough room left,
// or a new bin is opened; one result (bin_index, status, bins_used) follows
// on the out channel, taken when out_valid is high and out_stall low.
// An item that is too large, or finds no bin open, is settled with no scan; else
// the open bins are scanned in order, one stored capacity per cycle from the
// single read port of the capacity RAM. One item is worked on at a time: the next
// is taken only once the last result has left the sequencer. A waiting result sits
// in the output register; the next item is taken meanwhile but its result is held
// until the register is free. bin_capacity is written over the cfg channel
// (cfg_ready is always high); the user must do so only while the block is idle,
// which the block does not enforce. Reset empties every bin and sets the capacity
// to 65535; the RAM needs no clearing since only opened bins are ever read. An
// item with last_item set closes the set: all bins are empty afterwards.
module first_fit_bin_allocator import ffba_pkg::*; #(
	parameter int MAX_BINS  = MAX_BINS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ITEM_W-1:0]  bin_capacity,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ITEM_W-1:0]  item_size,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [INDEX_W-1:0] bin_index,
	output logic [1:0]         status,
	output logic [USED_W-1:0]  bins_used
);

	localparam int IdxW = $clog2(MAX_BINS);
	localparam logic [31:0] CapReset = 32'(CAP_RESET);

	logic [SIZE_BITS-1:0] cap_q;
	logic [31:0]          cfg_ext, size_ext;
	logic                 res_valid, res_take;
	res_t                 res, out_res_q;
	logic                 out_valid_q;

	logic                 ram_we, ram_re;
	logic [IdxW-1:0]      ram_waddr, ram_raddr;
	logic [SIZE_BITS-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_ext   = 32'(bin_capacity);
	assign size_ext  = 32'(item_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset[SIZE_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_ext[SIZE_BITS-1:0];
		end
	end

	ffba_ctrl #(
		.MAX_BINS  (MAX_BINS),
		.SIZE_BITS (SIZE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_size   (size_ext[SIZE_BITS-1:0]),
		.in_last   (last_item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ffba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_BINS)
	) u_cap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: loads when empty or being emptied this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign bin_index = out_res_q.bin_index;
	assign status    = out_res_q.status;
	assign bins_used = out_res_q.bins_used;

endmodule
